>>> design/sfp_pkg.sv
// shared types, constants and the crc step for the sync frame parser
`default_nettype none

package sfp_pkg;

    localparam int QUEUE_DEPTH = 2;

    // register indexes on the configuration port
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_PLAUS_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PLAUS_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LIVE_MIN   = 2'd2;
    localparam int CFG_DATA_W = 16;

    localparam logic [15:0] PLAUS_LOW_RST  = 16'd1000;
    localparam logic [15:0] PLAUS_HIGH_RST = 16'd3500;
    localparam logic [6:0]  LIVE_MIN_RST   = 7'd4;

    localparam logic [7:0] SYNC_FIRST  = 8'hFA;
    localparam logic [7:0] SYNC_SECOND = 8'hFD;
    localparam logic [7:0] MARK_HEAD   = 8'hFF;
    localparam logic [7:0] MARK_TAIL   = 8'hFE;
    localparam logic [7:0] OPC_LIVE    = 8'h21;
    localparam logic [7:0] OPC_PHASE   = 8'h22;
    localparam logic [7:0] MIN_LEN     = 8'd6;
    localparam logic [7:0] LIVE_MIN_LEN = 8'd24;
    localparam logic [7:0] CRC_INIT    = 8'hB8;
    localparam logic [7:0] CRC_POLY    = 8'h9C;
    localparam logic [7:0] CRC_XOUT    = 8'hFF;
    localparam logic [6:0] TALLY_MAX   = 7'd127;

    // frame positions
    localparam logic [7:0] POS_MARK_HEAD = 8'd3;
    localparam logic [7:0] POS_OPCODE    = 8'd4;
    localparam logic [7:0] POS_PAIR_MIN  = 8'd6;
    localparam logic [7:0] POS_LEN_DONE  = 8'd3;

    typedef enum logic [1:0] {
        CMD_DATA      = 2'd0,
        CMD_EOT       = 2'd1,
        CMD_BUS_RESET = 2'd2,
        CMD_UNUSED    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        OP_DATA  = 2'd0,
        OP_EOT   = 2'd1,
        OP_CLEAR = 2'd2
    } op_kind_t;

    typedef enum logic [1:0] {
        REPORT_DONE    = 2'd0,
        REPORT_BAD_LEN = 2'd1,
        REPORT_TRUNC   = 2'd2
    } report_kind_t;

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_SYNC2 = 2'd1,
        PH_LEN   = 2'd2,
        PH_BODY  = 2'd3
    } phase_t;

    // one classified beat on its way from front to back
    typedef struct packed {
        op_kind_t    kind;
        logic [7:0]  data;
        logic        is_sync_first;
        logic        is_sync_second;
        logic        is_mark_head;
        logic        is_mark_tail;
        logic        short_len;
    } op_t;

    typedef struct packed {
        report_kind_t kind;
        logic [7:0]   opcode;
        logic [7:0]   frame_length;
        logic         sum_ok;
        logic         markers_ok;
        logic [7:0]   crc_value;
        logic         crc_ok;
        logic         frame_valid;
        logic         phase_change;
        logic         live_values;
        logic [6:0]   plausible_count;
        logic [7:0]   bytes_received;
    } result_t;

    typedef struct packed {
        logic [15:0] plaus_low;
        logic [15:0] plaus_high;
        logic [6:0]  live_min;
    } cfg_t;

    // reflected crc-8, one byte
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> design/sfp_front.sv
// front end: takes stream beats and classifies them for the parser
`default_nettype none

module sfp_front (
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [1:0]    s_tuser,   // command
    input  wire logic [7:0]    s_tdata,   // data_byte
    input  wire logic          q_full,
    output logic               q_push,
    output sfp_pkg::op_t       q_op
);

    sfp_pkg::cmd_t cmd;

    assign cmd      = sfp_pkg::cmd_t'(s_tuser);
    assign s_tready = !q_full;

    always_comb
    begin
        q_op.data           = s_tdata;
        q_op.is_sync_first  = (s_tdata == sfp_pkg::SYNC_FIRST);
        q_op.is_sync_second = (s_tdata == sfp_pkg::SYNC_SECOND);
        q_op.is_mark_head   = (s_tdata == sfp_pkg::MARK_HEAD);
        q_op.is_mark_tail   = (s_tdata == sfp_pkg::MARK_TAIL);
        q_op.short_len      = (s_tdata < sfp_pkg::MIN_LEN);
        q_op.kind           = sfp_pkg::OP_DATA;
        q_push              = s_tvalid && !q_full;
        unique case (cmd)
            sfp_pkg::CMD_DATA:      q_op.kind = sfp_pkg::OP_DATA;
            sfp_pkg::CMD_EOT:       q_op.kind = sfp_pkg::OP_EOT;
            sfp_pkg::CMD_BUS_RESET: q_op.kind = sfp_pkg::OP_CLEAR;
            // unused command is taken and dropped here
            default:                q_push    = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

>>> design/sfp_queue.sv
// small fifo of classified beats between front and back
`default_nettype none

module sfp_queue #(
    parameter int DEPTH = sfp_pkg::QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire sfp_pkg::op_t  push_op,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output sfp_pkg::op_t       head_op
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    sfp_pkg::op_t     mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_op    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

>>> design/sfp_back.sv
// back end: frame parser state machine, running checks and result register
`default_nettype none

module sfp_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire sfp_pkg::cfg_t cfg,
    input  wire logic          q_valid,
    input  wire sfp_pkg::op_t  q_op,
    output logic               q_pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output sfp_pkg::result_t   result
);

    sfp_pkg::phase_t  phase_reg, phase_next;
    logic [7:0]       idx_reg, idx_next;
    logic [7:0]       len_reg, len_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       crc_reg, crc_next;
    logic [7:0]       opc_reg, opc_next;
    logic             marker_reg, marker_next;
    logic [7:0]       prev_reg, prev_next;
    logic [6:0]       tally_reg, tally_next;
    logic             out_valid_reg, out_valid_next;
    sfp_pkg::result_t res_reg, res_next;

    logic             go;
    logic [7:0]       b;
    logic [8:0]       idx_p2;
    logic [8:0]       len9;
    logic [7:0]       idx_inc;
    logic [7:0]       body_sum;
    logic [7:0]       body_crc;
    logic [7:0]       body_opc;
    logic             body_marker;
    logic [6:0]       body_tally;
    logic [15:0]      pair_val;
    logic             pair_hit;
    logic [7:0]       crc_final;
    logic             body_valid;
    logic             live_check;

    // a beat moves on whenever the result slot is free or being drained
    assign go       = q_valid && (!out_valid_reg || m_tready);
    assign q_pop    = go;
    assign m_tvalid = out_valid_reg;
    assign result   = res_reg;
    assign b        = q_op.data;

    // per-byte updates while collecting the frame body
    always_comb
    begin
        idx_p2   = {1'b0, idx_reg} + 9'd2;
        len9     = {1'b0, len_reg};
        idx_inc  = idx_reg + 8'd1;
        body_sum = sum_reg + b;
        body_crc = ((idx_reg >= sfp_pkg::POS_OPCODE) && (idx_p2 <= len9))
                   ? sfp_pkg::crc8_step(crc_reg, b) : crc_reg;
        body_opc = (idx_reg == sfp_pkg::POS_OPCODE) ? b : opc_reg;
        body_marker = marker_reg;
        if (idx_reg == sfp_pkg::POS_MARK_HEAD)
        begin
            body_marker = q_op.is_mark_head;
        end
        if ((idx_p2 == len9) && !q_op.is_mark_tail)
        begin
            body_marker = 1'b0;
        end
        // little-endian pair ends on an even index, tail marker and crc excluded
        pair_val = {b, prev_reg};
        pair_hit = (idx_reg >= sfp_pkg::POS_PAIR_MIN) && !idx_reg[0] && (idx_p2 < len9)
                   && (pair_val >= cfg.plaus_low) && (pair_val <= cfg.plaus_high)
                   && (tally_reg < sfp_pkg::TALLY_MAX);
        body_tally = pair_hit ? tally_reg + 7'd1 : tally_reg;
        crc_final  = body_crc ^ sfp_pkg::CRC_XOUT;
        body_valid = (body_sum == 8'd0) && body_marker;
        live_check = body_valid && (body_opc == sfp_pkg::OPC_LIVE)
                     && (len_reg >= sfp_pkg::LIVE_MIN_LEN);
    end

    always_comb
    begin
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        len_next       = len_reg;
        sum_next       = sum_reg;
        crc_next       = crc_reg;
        opc_next       = opc_reg;
        marker_next    = marker_reg;
        prev_next      = prev_reg;
        tally_next     = tally_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !m_tready;

        if (go)
        begin
            res_next = '0;
            case (q_op.kind)
                sfp_pkg::OP_CLEAR:
                begin
                    phase_next = sfp_pkg::PH_HUNT;
                end
                sfp_pkg::OP_EOT:
                begin
                    if (phase_reg != sfp_pkg::PH_HUNT)
                    begin
                        res_next.kind           = sfp_pkg::REPORT_TRUNC;
                        res_next.frame_length   = len_reg;
                        res_next.bytes_received = idx_reg;
                        out_valid_next          = 1'b1;
                        phase_next              = sfp_pkg::PH_HUNT;
                    end
                end
                sfp_pkg::OP_DATA:
                begin
                    unique case (phase_reg)
                        sfp_pkg::PH_HUNT:
                        begin
                            if (q_op.is_sync_first)
                            begin
                                phase_next = sfp_pkg::PH_SYNC2;
                            end
                        end
                        sfp_pkg::PH_SYNC2:
                        begin
                            if (q_op.is_sync_second)
                            begin
                                phase_next = sfp_pkg::PH_LEN;
                                idx_next   = 8'd2;
                                sum_next   = body_sum;
                            end
                            else if (!q_op.is_sync_first)
                            begin
                                phase_next = sfp_pkg::PH_HUNT;
                            end
                            // a repeated first sync byte keeps the hunt one step in
                        end
                        sfp_pkg::PH_LEN:
                        begin
                            if (q_op.short_len)
                            begin
                                res_next.kind           = sfp_pkg::REPORT_BAD_LEN;
                                res_next.frame_length   = b;
                                res_next.bytes_received = sfp_pkg::POS_LEN_DONE;
                                out_valid_next          = 1'b1;
                                phase_next              = sfp_pkg::PH_HUNT;
                            end
                            else
                            begin
                                phase_next = sfp_pkg::PH_BODY;
                                len_next   = b;
                                idx_next   = 8'd3;
                                sum_next   = body_sum;
                            end
                        end
                        sfp_pkg::PH_BODY:
                        begin
                            sum_next    = body_sum;
                            crc_next    = body_crc;
                            opc_next    = body_opc;
                            marker_next = body_marker;
                            tally_next  = body_tally;
                            prev_next   = b;
                            idx_next    = idx_inc;
                            if (idx_inc >= len_reg)
                            begin
                                res_next.kind            = sfp_pkg::REPORT_DONE;
                                res_next.opcode          = body_opc;
                                res_next.frame_length    = len_reg;
                                res_next.sum_ok          = (body_sum == 8'd0);
                                res_next.markers_ok      = body_marker;
                                res_next.crc_value       = crc_final;
                                res_next.crc_ok          = (crc_final == b);
                                res_next.frame_valid     = body_valid;
                                res_next.phase_change    = body_valid
                                                           && (body_opc == sfp_pkg::OPC_PHASE);
                                res_next.live_values     = live_check
                                                           && (body_tally >= cfg.live_min);
                                res_next.plausible_count = live_check ? body_tally : 7'd0;
                                res_next.bytes_received  = idx_inc;
                                out_valid_next           = 1'b1;
                                phase_next               = sfp_pkg::PH_HUNT;
                            end
                        end
                        default:
                        begin
                            phase_next = sfp_pkg::PH_HUNT;
                        end
                    endcase
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase

            // leaving for the hunt or a fresh start clears the frame state
            if (phase_next == sfp_pkg::PH_HUNT
                || (phase_next == sfp_pkg::PH_SYNC2 && q_op.kind == sfp_pkg::OP_DATA))
            begin
                idx_next    = (phase_next == sfp_pkg::PH_SYNC2) ? 8'd1 : 8'd0;
                sum_next    = (phase_next == sfp_pkg::PH_SYNC2) ? sfp_pkg::SYNC_FIRST : 8'd0;
                len_next    = 8'd0;
                crc_next    = sfp_pkg::CRC_INIT;
                opc_next    = 8'd0;
                marker_next = 1'b0;
                prev_next   = 8'd0;
                tally_next  = 7'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= sfp_pkg::PH_HUNT;
            idx_reg       <= 8'd0;
            len_reg       <= 8'd0;
            sum_reg       <= 8'd0;
            crc_reg       <= sfp_pkg::CRC_INIT;
            opc_reg       <= 8'd0;
            marker_reg    <= 1'b0;
            prev_reg      <= 8'd0;
            tally_reg     <= 7'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            len_reg       <= len_next;
            sum_reg       <= sum_next;
            crc_reg       <= crc_next;
            opc_reg       <= opc_next;
            marker_reg    <= marker_next;
            prev_reg      <= prev_next;
            tally_reg     <= tally_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

`default_nettype wire

>>> design/sync_frame_parser_with_checks_top.sv
// top level of the sync frame parser: config registers, front, queue, back
//
// Usage:
//   s_* carries one stream event per beat: s_tuser is the command (data byte,
//   end of short transfer, bus reset) and s_tdata the received byte. m_* carries
//   at most one report per event: m_tuser is the report kind (frame complete,
//   length rejected, frame truncated), m_tdata the checks and counters.
//   The parser hunts for FA FD, takes a length byte and tracks the sum, crc-8,
//   markers and plausible pairs byte by byte, reporting on the last byte.
//   Reports are registered: a taken beat is written into the queue, and the parser
//   reads the queue head and loads the result register.
//   Throughput: one beat per cycle while the result slot is free or being drained.
//   Configuration (cfg_we/cfg_index/cfg_data) is to be written by the user while
//   the block idles; the block itself does not enforce this. Reset clears the
//   parser to hunting, empties the queue and restores the plausible range
//   1000..3500 and live minimum 4. If m_tready is low the result register holds;
//   the queue then fills and s_tready drops after at most QUEUE_DEPTH more beats.
`default_nettype none

module sync_frame_parser_with_checks_top #(
    parameter int QUEUE_DEPTH = sfp_pkg::QUEUE_DEPTH
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [1:0]                         s_tuser,   // command
    input  wire logic [7:0]                         s_tdata,   // data_byte
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [1:0]                              m_tuser,   // report_kind
    // opcode, frame_length, sum_ok, markers_ok, crc_value, crc_ok, frame_valid,
    // phase_change, live_values, plausible_count, bytes_received, zero pad
    output logic [47:0]                             m_tdata,
    input  wire logic                               cfg_we,
    input  wire logic [sfp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [sfp_pkg::CFG_DATA_W-1:0]     cfg_data
);

    sfp_pkg::cfg_t    cfg_reg;
    sfp_pkg::op_t     push_op;
    sfp_pkg::op_t     head_op;
    sfp_pkg::result_t result;
    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.plaus_low  <= sfp_pkg::PLAUS_LOW_RST;
            cfg_reg.plaus_high <= sfp_pkg::PLAUS_HIGH_RST;
            cfg_reg.live_min   <= sfp_pkg::LIVE_MIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sfp_pkg::REG_PLAUS_LOW:  cfg_reg.plaus_low  <= cfg_data;
                sfp_pkg::REG_PLAUS_HIGH: cfg_reg.plaus_high <= cfg_data;
                sfp_pkg::REG_LIVE_MIN:   cfg_reg.live_min   <= cfg_data[6:0];
                default:                 cfg_reg            <= cfg_reg;
            endcase
        end
    end

    sfp_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_op     (push_op)
    );

    sfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_op    (push_op),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_op    (head_op)
    );

    sfp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_op     (head_op),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .result   (result)
    );

    assign m_tuser = result.kind;
    assign m_tdata = {3'b000,
                      result.bytes_received,
                      result.plausible_count,
                      result.live_values,
                      result.phase_change,
                      result.frame_valid,
                      result.crc_ok,
                      result.crc_value,
                      result.markers_ok,
                      result.sum_ok,
                      result.frame_length,
                      result.opcode};

    // queue never written while full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue written while full");

    // parser only steps on a queued beat
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // a frame cannot be both a phase change and a live reading
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[28] && m_tdata[29]))
        else $error("phase change and live values both set");

    // a report that was stalled is not dropped
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && !q_pop || m_tvalid))
        else $error("stalled report dropped");

endmodule

`default_nettype wire
